[design/maf_pkg.sv]
// maf_pkg: shared constants, controller states and command/status structs
// for the moving average filter; no dependencies
package maf_pkg;

   // default sizing of the filter
   localparam int MAX_WINDOW_DEFAULT = 64;
   localparam int SAMPLE_BITS_DEFAULT = 16;

   // window length register
   localparam int WINDOW_REG_BITS = 7;
   localparam logic [WINDOW_REG_BITS-1:0] WINDOW_RESET = 7'd8;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_LOAD,
      ST_DIVIDE,
      ST_FINISH
   } maf_state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic accept;
      logic zero_result;
      logic update;
      logic div_load;
      logic div_step;
      logic load_out;
   } maf_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic window_zero;
      logic div_last;
   } maf_status_type;

endpackage

[design/maf_sample_if.sv]
// maf_sample_if: valid/ready channel that carries one input sample word
// depends on maf_pkg for the default sample width
interface maf_sample_if
   import maf_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

[design/maf_average_if.sv]
// maf_average_if: valid/ready channel that carries one average word
// depends on maf_pkg for the default sample width
interface maf_average_if
   import maf_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] average;

   modport source (output valid, output average, input ready);
   modport sink (input valid, input average, output ready);
endinterface

[design/maf_ram.sv]
// maf_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module maf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 write_enable,
   input  logic [ADDR_BITS-1:0] write_address,
   input  logic [WIDTH-1:0]     write_data,
   input  logic [ADDR_BITS-1:0] read_address,
   output logic [WIDTH-1:0]     read_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      read_data_ff <= mem_ff[read_address];
   end

   assign read_data = read_data_ff;
endmodule

[design/maf_ctrl.sv]
// maf_ctrl: controller state machine and output valid register of the filter
// depends on maf_pkg for states, commands and status
module maf_ctrl
   import maf_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  maf_status_type status,
   output maf_cmd_type    cmd
);
   maf_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // state and output valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (status.window_zero) begin
                  cmd.zero_result = 1'b1;
                  state_in        = ST_FINISH;
               end else begin
                  state_in = ST_UPDATE;
               end
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.div_load = 1'b1;
            state_in     = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output word held until taken
   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_load_shows_word: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid_ff)
      else $error("loaded result not presented");

   a_divide_runs_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) && !status.div_last |=> (state_ff == ST_DIVIDE))
      else $error("divider left before its last step");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> (state_ff != ST_IDLE))
      else $error("accepted word did not start work");
endmodule

[design/maf_datapath.sv]
// maf_datapath: window register, sample store, running sum and bit-serial
// floor divider of the filter; depends on maf_pkg and maf_ram
module maf_datapath
   import maf_pkg::*;
#(
   parameter int MAX_WINDOW  = MAX_WINDOW_DEFAULT,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [WINDOW_REG_BITS-1:0]    csr_write_data,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic signed [SAMPLE_BITS-1:0] rsp_average,
   input  maf_cmd_type                   cmd,
   output maf_status_type                status
);
   localparam int ADDR_BITS  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int WIN_BITS   = $clog2(MAX_WINDOW + 1);
   localparam int CMP_BITS   = (WIN_BITS > WINDOW_REG_BITS) ? WIN_BITS : WINDOW_REG_BITS;
   localparam int SUM_BITS   = SAMPLE_BITS + $clog2(MAX_WINDOW) + 1;
   localparam int COUNT_BITS = $clog2(SUM_BITS);

   logic [WINDOW_REG_BITS-1:0]    window_ff;
   logic [ADDR_BITS-1:0]          pos_ff, pos_in;
   logic                          wrapped_ff;
   logic signed [SUM_BITS-1:0]    sum_ff, sum_in;
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic [SUM_BITS-1:0]           quot_ff, quot_in;
   logic [WIN_BITS-1:0]           rem_ff, rem_in;
   logic                          neg_ff, neg_in;
   logic [COUNT_BITS-1:0]         count_ff, count_in;
   logic signed [SAMPLE_BITS-1:0] average_ff;

   logic [CMP_BITS-1:0]           window_ext;
   logic [WIN_BITS-1:0]           eff_window;
   logic [ADDR_BITS-1:0]          pos_use;
   logic [WIN_BITS-1:0]           pos_plus;
   logic [SAMPLE_BITS-1:0]        ram_rdata;
   logic signed [SAMPLE_BITS-1:0] old_sample;
   logic [SUM_BITS-1:0]           sum_bits;
   logic [SUM_BITS-1:0]           sum_magnitude;
   logic [WIN_BITS:0]             rem_shifted;
   logic                          quot_bit;
   logic [SUM_BITS-1:0]           floor_result;

   // window clamped to the store depth
   assign window_ext = CMP_BITS'(window_ff);
   assign eff_window = (window_ext > CMP_BITS'(MAX_WINDOW)) ? WIN_BITS'(MAX_WINDOW)
                                                            : WIN_BITS'(window_ext);

   // slot to replace and the position after it
   assign pos_use  = (WIN_BITS'(pos_ff) >= eff_window) ? '0 : pos_ff;
   assign pos_plus = WIN_BITS'(pos_use) + WIN_BITS'(1);
   assign pos_in   = (pos_plus >= eff_window) ? '0 : ADDR_BITS'(pos_plus);

   // sample store
   maf_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MAX_WINDOW)
   ) u_store (
      .clock         (clock),
      .write_enable  (cmd.update),
      .write_address (pos_use),
      .write_data    (sample_ff),
      .read_address  (pos_use),
      .read_data     (ram_rdata)
   );

   // slots are filled in order after a clear, so until the position wraps
   // the slot to replace has not been written and reads as zero
   assign old_sample = wrapped_ff ? signed'(ram_rdata) : '0;
   assign sum_in     = sum_ff - SUM_BITS'(old_sample) + SUM_BITS'(sample_ff);

   // window register and history
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff  <= WINDOW_RESET;
         pos_ff     <= '0;
         wrapped_ff <= 1'b0;
         sum_ff     <= '0;
      end else if (csr_write_enable) begin
         window_ff  <= csr_write_data;
         pos_ff     <= '0;
         wrapped_ff <= 1'b0;
         sum_ff     <= '0;
      end else if (cmd.update) begin
         pos_ff <= pos_in;
         if (pos_plus >= eff_window) begin
            wrapped_ff <= 1'b1;
         end
         sum_ff <= sum_in;
      end
   end

   // sample capture
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sample_ff <= req_sample;
      end
   end

   // restoring divider on the sum magnitude, one quotient bit per cycle
   assign sum_bits      = sum_ff;
   assign sum_magnitude = sum_bits[SUM_BITS-1] ? (~sum_bits + SUM_BITS'(1)) : sum_bits;
   assign rem_shifted   = {rem_ff, quot_ff[SUM_BITS-1]};
   assign quot_bit      = rem_shifted >= {1'b0, eff_window};

   always_comb begin
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      neg_in   = neg_ff;
      count_in = count_ff;
      if (cmd.zero_result) begin
         quot_in = '0;
         rem_in  = '0;
         neg_in  = 1'b0;
      end else if (cmd.div_load) begin
         quot_in  = sum_magnitude;
         rem_in   = '0;
         neg_in   = sum_bits[SUM_BITS-1];
         count_in = '0;
      end else if (cmd.div_step) begin
         quot_in  = {quot_ff[SUM_BITS-2:0], quot_bit};
         rem_in   = quot_bit ? WIN_BITS'(rem_shifted - {1'b0, eff_window})
                             : WIN_BITS'(rem_shifted);
         count_in = count_ff + COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
      neg_ff   <= neg_in;
      count_ff <= count_in;
   end

   // negative sums round down: -q when exact, -q-1 otherwise
   assign floor_result = !neg_ff ? quot_ff
                       : ((rem_ff != '0) ? ~quot_ff : (~quot_ff + SUM_BITS'(1)));

   // output register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         average_ff <= signed'(floor_result[SAMPLE_BITS-1:0]);
      end
   end

   assign rsp_average        = average_ff;
   assign status.window_zero = (eff_window == '0);
   assign status.div_last    = (count_ff == COUNT_BITS'(SUM_BITS - 1));

   a_position_in_window: assert property (@(posedge clock) disable iff (reset)
      !status.window_zero |-> (WIN_BITS'(pos_ff) < eff_window))
      else $error("write position outside the window");

   a_remainder_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |=> (rem_ff < eff_window))
      else $error("divider remainder not below window");
endmodule

[design/moving_average_filter.sv]
// Moving average filter: each accepted sample word replaces the oldest of the
// last window_length samples and yields one average word, the floor of the
// window sum divided by the window length (zeros stand in for samples not yet
// seen). Writing window_length clears the history; a length of zero gives 0
// and leaves the history as it is, and lengths above MAX_WINDOW act as
// MAX_WINDOW. One word is in work at a time: after acceptance it passes through
// the update, load, divide and finish states, and the controller takes the next
// word only once the result has been loaded. The bit-serial divider, one quotient
// bit per cycle, works on the SUM_BITS-bit window sum, where SUM_BITS =
// SAMPLE_BITS + clog2(MAX_WINDOW) + 1. A zero window skips the update and the
// divider and goes straight to loading its result.
// A finished result waits in an output register while the next word is taken;
// the next result then waits until the output register is free.
// Depends on maf_pkg, maf_sample_if, maf_average_if, maf_ctrl, maf_datapath.
module moving_average_filter
   import maf_pkg::*;
#(
   parameter int MAX_WINDOW  = MAX_WINDOW_DEFAULT,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [WINDOW_REG_BITS-1:0] csr_write_data,
   maf_sample_if.sink                 req_if,
   maf_average_if.source              rsp_if
);
   maf_cmd_type    cmd;
   maf_status_type status;

   // controller
   maf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   maf_datapath #(
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_sample       (req_if.sample),
      .rsp_average      (rsp_if.average),
      .cmd              (cmd),
      .status           (status)
   );
endmodule
